@@ hdl/mmcs_pkg.sv @@
// Shared types and constants of the min-max contrast stretch block.
package mmcs_pkg;

    localparam int PIX_W     = 8;                // grayscale pixel width
    localparam int DIV_STEPS = PIX_W;            // quotient bits, one per divide step
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = 17;               // holds 510*254 + 255
    localparam int DVS_W     = 2 * PIX_W;        // (2*d) << (DIV_STEPS-1) = d << 8

    localparam logic [PIX_W-1:0] UNIFORM_VAL = PIX_W'(128);
    localparam logic [PIX_W-1:0] FLOOR_VAL   = PIX_W'(0);
    localparam logic [PIX_W-1:0] CEIL_VAL    = PIX_W'(255);

    localparam logic KIND_GATHER = 1'b0;
    localparam logic KIND_APPLY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic gather_req;   // fold the accepted pixel into the statistics
        logic apply_req;    // latch the accepted pixel and set up the divide
        logic div_step;     // run one restoring divide step
        logic out_load;     // move the quotient into the output register
    } mmcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;     // output register holds a request that is not taken this cycle
    } mmcs_stat_t;

endpackage

@@ hdl/min_max_contrast_stretch.sv @@
// Top level of the min-max contrast stretch block.
//
// Two-pass linear contrast stretch of 8-bit grayscale pixels.
// Input channel (s_*): s_tuser is the kind, 0 for a gather pixel that updates
// the min/max statistics, 1 for an apply pixel that returns a stretched value.
// s_tdata carries the pixel, s_tlast marks the final pixel of a pass.
// Output channel (m_*): one request per apply pixel, m_tdata is the stretched
// pixel, m_tlast copies the apply pixel's last flag. Gather pixels give none.
// Gather pixels are accepted back to back; an apply pixel runs through accept,
// eight restoring divide steps of one quotient bit each and hand-off in the
// shared bit-serial divider before the next pixel is accepted.
// s_tready is high only while the sequencer is idle.
// The output register parts the two sides: a new pixel is accepted while a
// finished result waits; when the receiver stalls, the next apply result
// holds in the divider until the output register is taken.
// Reset (aresetn low, synchronous) clears the statistics to min = max = 0,
// so apply pixels before any gather return 128, and empties the output.
module min_max_contrast_stretch import mmcs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // [7:0] pixel
    input  logic             s_tuser,   // [0] kind
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,   // [7:0] out_pixel
    output logic             m_tlast
);

    mmcs_cmd_t  cmd;
    mmcs_stat_t stat;

    // sequencer: handshake on the input side and divide step count
    mmcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // statistics, divider and output register
    mmcs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hdl/mmcs_ctrl.sv @@
// Sequencer of the min-max contrast stretch block: accept, divide, hand off.
module mmcs_ctrl import mmcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    input  mmcs_stat_t stat,
    output mmcs_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.gather_req = accept && (s_tuser == KIND_GATHER);
        cmd.apply_req  = accept && (s_tuser == KIND_APPLY);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.apply_req) begin
                    state_next = ST_DIV;
                    cnt_next   = STEP_W'(DIV_STEPS - 1);
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                // hold until the output register frees up
                if (!stat.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hdl/mmcs_dp.sv @@
// Datapath of the min-max contrast stretch block: statistics, divider, output register.
module mmcs_dp import mmcs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [PIX_W-1:0] s_tdata,
    input  logic             s_tlast,
    input  mmcs_cmd_t        cmd,
    output mmcs_stat_t       stat,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic             m_tlast
);

    logic [PIX_W-1:0] low_reg, high_reg;
    logic             open_reg;
    logic [REM_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [PIX_W-1:0] quot_reg;
    logic             special_reg;
    logic             last_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_last_reg;

    logic [PIX_W-1:0] diff, span;
    logic             is_uniform, is_below, is_above;
    logic [REM_W-1:0] num;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign diff       = s_tdata - low_reg;
    assign span       = high_reg - low_reg;
    assign is_uniform = (low_reg >= high_reg);
    assign is_below   = (s_tdata <= low_reg);
    assign is_above   = (s_tdata >= high_reg);
    // 510*diff + span
    assign num = {diff, 9'b0} - {8'b0, diff, 1'b0} + {9'b0, span};

    assign trial = rem_reg - {1'b0, dvs_reg};
    assign fits  = (rem_reg >= {1'b0, dvs_reg});

    // statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
            open_reg <= 1'b0;
        end else if (cmd.gather_req) begin
            if (!open_reg) begin
                low_reg  <= s_tdata;
                high_reg <= s_tdata;
            end else begin
                if (s_tdata < low_reg) low_reg <= s_tdata;
                if (s_tdata > high_reg) high_reg <= s_tdata;
            end
            open_reg <= !s_tlast;
        end else if (cmd.apply_req) begin
            open_reg <= 1'b0;
        end
    end

    // restoring divider; the quotient stays below 256 inside the range
    always_ff @(posedge aclk) begin
        if (cmd.apply_req) begin
            rem_reg     <= num;
            dvs_reg     <= {span, 8'b0};
            last_reg    <= s_tlast;
            special_reg <= is_uniform || is_below || is_above;
            if (is_uniform) begin
                quot_reg <= UNIFORM_VAL;
            end else if (is_below) begin
                quot_reg <= FLOOR_VAL;
            end else if (is_above) begin
                quot_reg <= CEIL_VAL;
            end else begin
                quot_reg <= '0;
            end
        end else if (cmd.div_step && !special_reg) begin
            if (fits) rem_reg <= trial;
            quot_reg <= {quot_reg[PIX_W-2:0], fits};
            dvs_reg  <= dvs_reg >> 1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_pixel_reg <= quot_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign stat.out_full = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_pixel_reg;
    assign m_tlast       = out_last_reg;

endmodule

@@ sim/min_max_contrast_stretch_test.sv @@
// Self-checking testbench for the min-max contrast stretch block.
module min_max_contrast_stretch_test import mmcs_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 6;     // 12 ns period
    localparam int RESET_CYCLES   = 5;
    localparam int RESULT_LATENCY = 9;     // settling wait once no results are outstanding
    localparam int STALL_LIMIT    = 2000;  // cycles with no request moving on either side
    localparam int LONG_HOLD      = 300;   // receiver hold-off for the backpressure test
    localparam int MAX_REPORTS    = 10;

    // One expected stretched pixel.
    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } stretched_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [PIX_W-1:0] s_tdata  = '0;    // [7:0] pixel
    logic             s_tuser  = 1'b0;  // [0] kind
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [PIX_W-1:0] m_tdata;          // [7:0] out_pixel
    logic             m_tlast;

    // Predictor state: statistics of the current or latest gather pass.
    logic [PIX_W-1:0] stat_min  = '0;
    logic [PIX_W-1:0] stat_max  = '0;
    logic             pass_open = 1'b0;

    stretched_t stretched_q[$];   // expected results, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;        // hold-offs requested by the tests
    int hold_taken    = 0;        // hold-offs picked up by the receiver
    int hold_left     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    min_max_contrast_stretch dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Map p from [lo, hi] onto 0..255 with exact round-half-up; a flat range gives mid-gray.
    function automatic logic [PIX_W-1:0] stretched_value(logic [PIX_W-1:0] p,
                                                         logic [PIX_W-1:0] lo,
                                                         logic [PIX_W-1:0] hi);
        int unsigned span;
        int unsigned offs;
        if (lo >= hi) return UNIFORM_VAL;
        if (p <= lo) return FLOOR_VAL;
        if (p >= hi) return CEIL_VAL;
        span = int'(hi) - int'(lo);
        offs = int'(p) - int'(lo);
        return PIX_W'((510 * offs + span) / (2 * span));
    endfunction

    // Fold one accepted request into the statistics, or queue its stretched pixel.
    function automatic void track_request(logic kind, logic [PIX_W-1:0] pixel, logic last);
        if (kind == KIND_GATHER) begin
            if (!pass_open) begin
                stat_min  = pixel;
                stat_max  = pixel;
                pass_open = 1'b1;
            end else begin
                if (pixel < stat_min) stat_min = pixel;
                if (pixel > stat_max) stat_max = pixel;
            end
            if (last) pass_open = 1'b0;
        end else begin
            // An apply pixel closes any open gather pass.
            pass_open = 1'b0;
            stretched_q.push_back('{stretched_value(pixel, stat_min, stat_max), last});
        end
    endfunction

    function automatic void report_mismatch(string what, int exp_val, int act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_val,
                     act_val);
    endfunction

    // Offer one request, with random idle cycles first, and hold it until accepted.
    task automatic send_pixel(input logic kind, input logic [PIX_W-1:0] pixel,
                              input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pixel;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_request(kind, pixel, last);
    endtask

    // Drop valid and pause until every expected result is back, then let the pipe settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (stretched_q.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY) @(posedge aclk);
    endtask

    // Extremes and the named corner cases: apply before any gather, out-of-range
    // pixels, apply during an open gather, flat image, full 0..255 range.
    task automatic test_directed_cases();
        // apply with reset statistics: mid-gray
        send_pixel(KIND_APPLY, 8'd0, 1'b0);
        send_pixel(KIND_APPLY, 8'd255, 1'b1);
        // normal gather pass 50..200
        send_pixel(KIND_GATHER, 8'd50, 1'b0);
        send_pixel(KIND_GATHER, 8'd200, 1'b0);
        send_pixel(KIND_GATHER, 8'd120, 1'b1);
        // below min, above max, on the low end, inside
        send_pixel(KIND_APPLY, 8'd0, 1'b0);
        send_pixel(KIND_APPLY, 8'd255, 1'b0);
        send_pixel(KIND_APPLY, 8'd50, 1'b0);
        send_pixel(KIND_APPLY, 8'd137, 1'b1);
        // apply while gather is still open: uses partial stats and closes the pass
        send_pixel(KIND_GATHER, 8'd10, 1'b0);
        send_pixel(KIND_GATHER, 8'd20, 1'b0);
        send_pixel(KIND_APPLY, 8'd15, 1'b1);
        // flat image after a fresh start
        send_pixel(KIND_GATHER, 8'd77, 1'b1);
        send_pixel(KIND_APPLY, 8'd77, 1'b0);
        send_pixel(KIND_APPLY, 8'd255, 1'b1);
        // full range
        send_pixel(KIND_GATHER, 8'd0, 1'b0);
        send_pixel(KIND_GATHER, 8'd255, 1'b1);
        send_pixel(KIND_APPLY, 8'd1, 1'b0);
        send_pixel(KIND_APPLY, 8'd128, 1'b1);
        wait_drained();
    endtask

    // Mostly well-formed gather/apply pass pairs with random content, some noise
    // and some passes with the last marker missing.
    task automatic test_random_passes(input int n_items);
        int sent;
        int len;
        int lo;
        int hi;
        logic [PIX_W-1:0] pix;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 10) begin
                send_pixel(1'($urandom_range(1)), PIX_W'($urandom_range(255)),
                           1'($urandom_range(1)));
                sent++;
            end else begin
                // mostly short images, now and then a longer one
                len = ($urandom_range(9) == 0) ? $urandom_range(48, 1) : $urandom_range(12, 1);
                lo  = $urandom_range(255);
                hi  = ($urandom_range(19) == 0) ? lo : $urandom_range(255, lo);
                for (int i = 0; i < len; i++) begin
                    pix = ($urandom_range(19) == 0) ? PIX_W'($urandom_range(255))
                                                    : PIX_W'($urandom_range(hi, lo));
                    // occasionally leave the pass open
                    send_pixel(KIND_GATHER, pix,
                               (i == len - 1) && ($urandom_range(19) != 0));
                end
                for (int i = 0; i < len; i++) begin
                    pix = ($urandom_range(4) == 0) ? PIX_W'($urandom_range(255))
                                                   : PIX_W'($urandom_range(hi, lo));
                    send_pixel(KIND_APPLY, pix, i == len - 1);
                end
                sent += 2 * len;
            end
        end
        wait_drained();
    endtask

    // Hold off the receiver for a long stretch while apply pixels keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        send_pixel(KIND_GATHER, 8'd30, 1'b0);
        send_pixel(KIND_GATHER, 8'd220, 1'b1);
        hold_asks++;
        for (int i = 0; i < 24; i++)
            send_pixel(KIND_APPLY, PIX_W'($urandom_range(255)), i == 23);
        send_idle_pct = saved_idle;
        wait_drained();
    endtask

    // Receiver: random ready, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_taken != hold_asks) begin
            hold_left  = LONG_HOLD - 1;
            hold_taken = hold_asks;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        stretched_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (stretched_q.size() == 0) begin
                report_mismatch("unexpected result, out_pixel", -1, int'(m_tdata));
            end else begin
                want = stretched_q.pop_front();
                if (m_tdata !== want.pixel)
                    report_mismatch("out_pixel", int'(want.pixel), int'(m_tdata));
                if (m_tlast !== want.last)
                    report_mismatch("out_last", int'(want.last), int'(m_tlast));
            end
        end
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("[min_max_contrast_stretch] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // sender sparse-ish, receiver mostly stalled
        send_idle_pct = 23;
        recv_idle_pct = 63;
        test_directed_cases();
        test_random_passes(330);
        test_output_backpressure();

        // swap the idling of the two sides
        send_idle_pct = 63;
        recv_idle_pct = 23;
        test_random_passes(330);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_passes(330);

        repeat (2 * RESULT_LATENCY) @(posedge aclk);
        if (mismatches == 0 && stretched_q.size() == 0) begin
            $display("[min_max_contrast_stretch] OK");
        end else begin
            $display("[min_max_contrast_stretch] ERROR");
        end
        $finish;
    end

endmodule
